[src/ntmp_pkg.sv]
// shared types, constants and register codes of the normalized trapezoid motion profile
package ntmp_pkg;

    localparam int TICKS = 1000;

    // register indexes on the configuration port
    localparam logic [1:0] REG_PEAK_VELOCITY = 2'd0;
    localparam logic [1:0] REG_ACCELERATION  = 2'd1;

    // reset value of both registers, 1.0 in q8.16
    localparam logic [23:0] CFG_ONE = 24'd65536;

    // position full scale, 1.0 in q2.16
    localparam logic [17:0] POS_ONE = 18'd65536;

    // ticks * 2^17 and ticks * 2^16
    localparam logic [26:0] FULL_TRI = 27'(TICKS * 131072);
    localparam logic [25:0] HALF_TRI = 26'(TICKS * 65536);

    // divisors that do not depend on the registers
    localparam logic [84:0] D_TRI = (85'(TICKS) * 85'(TICKS)) << 17;
    localparam logic [84:0] D_ACC = 85'(2 * TICKS * TICKS);

    // derivation sequencer has 52 restoring steps per division
    localparam logic [5:0] DIV_LAST = 6'd51;

    typedef enum logic [2:0] {
        DRV_IDLE,
        DRV_PREP,
        DRV_MUL,
        DRV_LOAD,
        DRV_DIV_PER,
        DRV_DIV_AT
    } t_drv_state;

    typedef enum logic [2:0] {
        PH_TRI_ACC,
        PH_TRI_DEC,
        PH_TRP_ACC,
        PH_TRP_CRU,
        PH_TRP_DEC
    } t_phase;

    // values derived from the registers, held for the datapath
    typedef struct packed {
        logic        tri_mode;
        logic [31:0] period;
        logic [31:0] accel_time;
        logic [50:0] k;
        logic [49:0] vvt;
        logic [34:0] at2;
        logic [84:0] ddec;
        logic [23:0] v;
        logic [23:0] a;
    } t_derived;

    // one step of the tick modulo chain
    typedef struct packed {
        logic        valid;
        logic        odd;
        logic [31:0] rem;
        logic [30:0] dividend;
    } t_mod;

    // one step of the position divider chain
    typedef struct packed {
        logic         valid;
        logic         odd;
        logic         ceil_mode;
        logic         sat;
        logic [101:0] rem;
        logic [100:0] dsh;
        logic [16:0]  q;
    } t_div;

endpackage

[src/ntmp_mod_cell.sv]
// one restoring step of the tick modulo period chain
module ntmp_mod_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic [31:0]    i_divisor,
    input  ntmp_pkg::t_mod i_d,
    output ntmp_pkg::t_mod o_q
);
    import ntmp_pkg::*;

    t_mod r_q;
    t_mod n_q;

    always_comb begin
        logic [32:0] x;
        logic        ge;
        x  = {i_d.rem, i_d.dividend[30]};
        ge = x >= {1'b0, i_divisor};
        n_q          = i_d;
        n_q.rem      = ge ? 32'(x - {1'b0, i_divisor}) : x[31:0];
        n_q.dividend = {i_d.dividend[29:0], 1'b0};
        n_q.odd      = ge;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

[src/ntmp_div_cell.sv]
// one restoring step of the position quotient chain
module ntmp_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  ntmp_pkg::t_div i_d,
    output ntmp_pkg::t_div o_q
);
    import ntmp_pkg::*;

    t_div r_q;
    t_div n_q;

    always_comb begin
        logic ge;
        ge = i_d.rem >= {1'b0, i_d.dsh};
        n_q     = i_d;
        n_q.rem = ge ? 102'(i_d.rem - {1'b0, i_d.dsh}) : i_d.rem;
        n_q.dsh = i_d.dsh >> 1;
        n_q.q   = {i_d.q[15:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

[src/ntmp_derive.sv]
// configuration registers and sequencer that derives period and phase limits
module ntmp_derive (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    output ntmp_pkg::t_derived o_drv,
    output logic               o_busy
);
    import ntmp_pkg::*;

    t_drv_state r_state;
    t_drv_state n_state;

    logic [23:0] r_v;
    logic [23:0] r_a;
    logic [47:0] r_vv;
    logic [47:0] r_va;
    logic        r_tri;
    logic [50:0] r_k;
    logic [49:0] r_vvt;
    logic [34:0] r_at2;
    logic [84:0] r_ddec;
    logic [51:0] r_num;
    logic [47:0] r_den;
    logic [48:0] r_rem;
    logic [51:0] r_quo;
    logic [5:0]  r_cnt;
    logic [31:0] r_period;
    logic [31:0] r_atime;

    logic        s_cfg_hit;
    logic [23:0] s_cfg_val;
    logic        s_last;
    logic [48:0] s_rem_n;
    logic [51:0] s_quo_n;
    logic [31:0] s_quo_sat;
    logic [58:0] s_kfull;
    logic [57:0] s_vvt_full;
    logic [84:0] s_ddec;

    assign s_cfg_val = (i_cfg_data == 24'd0) ? 24'd1 : i_cfg_data;
    assign s_cfg_hit = i_cfg_we
        && (i_cfg_index == REG_PEAK_VELOCITY || i_cfg_index == REG_ACCELERATION);
    assign s_last = r_cnt == DIV_LAST;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            DRV_PREP:    n_state = DRV_MUL;
            DRV_MUL:     n_state = DRV_LOAD;
            DRV_LOAD:    n_state = DRV_DIV_PER;
            DRV_DIV_PER: if (s_last) n_state = DRV_DIV_AT;
            DRV_DIV_AT:  if (s_last) n_state = DRV_IDLE;
            DRV_IDLE:    n_state = DRV_IDLE;
            default:     n_state = DRV_IDLE;
        endcase
        if (s_cfg_hit) begin
            n_state = DRV_PREP;
        end
    end

    // outputs
    always_comb begin
        case (r_state)
            DRV_IDLE: o_busy = 1'b0;
            default:  o_busy = 1'b1;
        endcase
    end

    // shared restoring step and derived products
    always_comb begin
        logic [48:0] x;
        logic        ge;
        x       = {r_rem[47:0], r_num[51]};
        ge      = x >= {1'b0, r_den};
        s_rem_n = ge ? 49'(x - {1'b0, r_den}) : x;
        s_quo_n = {r_quo[50:0], ge};
        s_quo_sat = (s_quo_n[51:32] != 20'd0) ? 32'hFFFF_FFFF : s_quo_n[31:0];
        s_kfull    = 59'(TICKS) * (59'({r_a, 16'd0}) + 59'(r_vv));
        s_vvt_full = 58'(r_vv) * 58'(TICKS);
        s_ddec = (85'(60'(r_vvt[49:25]) * 60'(r_at2)) << 25)
               + 85'(60'(r_vvt[24:0]) * 60'(r_at2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DRV_PREP;
            r_v     <= CFG_ONE;
            r_a     <= CFG_ONE;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && i_cfg_index == REG_PEAK_VELOCITY) begin
                r_v <= s_cfg_val;
            end
            if (i_cfg_we && i_cfg_index == REG_ACCELERATION) begin
                r_a <= s_cfg_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            DRV_PREP: begin
                r_vv <= 48'(r_v) * 48'(r_v);
                r_va <= 48'(r_v) * 48'(r_a);
            end
            DRV_MUL: begin
                r_tri <= r_vv >= {8'd0, r_a, 16'd0};
                r_k   <= s_kfull[50:0];
                r_vvt <= s_vvt_full[49:0];
                r_at2 <= 35'(r_a) * 35'(2 * TICKS);
            end
            DRV_LOAD: begin
                r_ddec <= s_ddec;
                r_num  <= r_tri ? 52'(FULL_TRI) : {1'b0, r_k};
                r_den  <= r_tri ? 48'(r_v) : r_va;
                r_rem  <= '0;
                r_quo  <= '0;
                r_cnt  <= '0;
            end
            DRV_DIV_PER: begin
                if (s_last) begin
                    // a period under one tick is held at one tick
                    r_period <= (s_quo_sat == 32'd0) ? 32'd1 : s_quo_sat;
                    r_num <= r_tri ? 52'(HALF_TRI) + 52'(r_v) - 52'd1
                                   : 52'(34'(r_v) * 34'(TICKS)) + 52'(r_a) - 52'd1;
                    r_den <= r_tri ? 48'(r_v) : 48'(r_a);
                    r_rem <= '0;
                    r_quo <= '0;
                    r_cnt <= '0;
                end else begin
                    r_num <= {r_num[50:0], 1'b0};
                    r_rem <= s_rem_n;
                    r_quo <= s_quo_n;
                    r_cnt <= r_cnt + 6'd1;
                end
            end
            DRV_DIV_AT: begin
                r_num <= {r_num[50:0], 1'b0};
                r_rem <= s_rem_n;
                r_quo <= s_quo_n;
                r_cnt <= r_cnt + 6'd1;
                if (s_last) begin
                    r_atime <= s_quo_sat;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_drv.tri_mode   = r_tri;
    assign o_drv.period     = r_period;
    assign o_drv.accel_time = r_atime;
    assign o_drv.k          = r_k;
    assign o_drv.vvt        = r_vvt;
    assign o_drv.at2        = r_at2;
    assign o_drv.ddec       = r_ddec;
    assign o_drv.v          = r_v;
    assign o_drv.a          = r_a;

endmodule

[src/normalized_trapezoid_motion_profile.sv]
// top level of the normalized trapezoid motion profile
//
// channel  direction  handshake                  payload
// in       input      i_in_valid / o_in_stall    i_tick_count
// out      output     o_out_valid / i_out_stall  o_position, o_odd_period
// cfg      input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// one transaction per cycle while the input is not stalled; the path runs through 31 modulo
// cells, five arithmetic stages, 17 quotient cells and the output register
// after reset and after each register write the derivation sequencer runs its prepare,
// multiply and load steps and two 52-step divisions on one shared step, input stalled
// the output register has one spare slot behind it; the whole chain freezes
// only when both hold a result that has not been taken
module normalized_trapezoid_motion_profile (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [30:0] i_tick_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [17:0] o_position,
    output logic        o_odd_period,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    import ntmp_pkg::*;

    t_derived s_drv;
    logic     s_busy;
    logic     s_en;

    t_mod s_mod [0:31];
    t_div s_div [0:17];

    // derived state and register file
    ntmp_derive u_derive (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_drv       (s_drv),
        .o_busy      (s_busy)
    );

    // chain moves whenever the output side has room
    logic [1:0] r_cnt;
    assign s_en       = r_cnt != 2'd2;
    assign o_in_stall = !s_en || s_busy;

    // tick modulo period, one dividend bit per cell; last quotient bit is the parity
    assign s_mod[0].valid    = i_in_valid && !o_in_stall;
    assign s_mod[0].odd      = 1'b0;
    assign s_mod[0].rem      = '0;
    assign s_mod[0].dividend = i_tick_count;

    for (genvar gi = 0; gi < 31; gi++) begin : g_mod
        ntmp_mod_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (s_en),
            .i_divisor (s_drv.period),
            .i_d       (s_mod[gi]),
            .o_q       (s_mod[gi + 1])
        );
    end

    // stage 1: velocity times tick, acceleration phase test
    logic        r1_valid;
    logic        r1_odd;
    logic        r1_accel;
    logic [17:0] r1_t18;
    logic [55:0] r1_vt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (s_en) begin
            r1_valid <= s_mod[31].valid;
            r1_odd   <= s_mod[31].odd;
            r1_accel <= s_mod[31].rem < s_drv.accel_time;
            r1_t18   <= s_mod[31].rem[17:0];
            r1_vt    <= 56'(s_drv.v) * 56'(s_mod[31].rem);
        end
    end

    // stage 2: pick the phase and its first product
    t_phase      n2_phase;
    logic [26:0] n2_x;
    logic [26:0] n2_y;
    logic [26:0] s_m_tri;

    always_comb begin
        logic cru;
        cru     = r1_vt < 56'(HALF_TRI);
        s_m_tri = (r1_vt < 56'(FULL_TRI)) ? 27'(56'(FULL_TRI) - r1_vt) : 27'd0;
        if (s_drv.tri_mode) begin
            n2_phase = r1_accel ? PH_TRI_ACC : PH_TRI_DEC;
        end else if (r1_accel) begin
            n2_phase = PH_TRP_ACC;
        end else begin
            n2_phase = cru ? PH_TRP_CRU : PH_TRP_DEC;
        end
        case (n2_phase)
            PH_TRI_ACC: begin
                n2_x = r1_vt[26:0];
                n2_y = r1_vt[26:0];
            end
            PH_TRI_DEC: begin
                n2_x = s_m_tri;
                n2_y = s_m_tri;
            end
            PH_TRP_ACC: begin
                n2_x = 27'(r1_t18);
                n2_y = 27'(s_drv.a);
            end
            default: begin
                // cruise and deceleration both need a * v * t
                n2_x = r1_vt[26:0];
                n2_y = 27'(s_drv.a);
            end
        endcase
    end

    logic        r2_valid;
    logic        r2_odd;
    t_phase      r2_phase;
    logic [53:0] r2_p2;
    logic [17:0] r2_t18;
    logic        r2_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (s_en) begin
            r2_valid <= r1_valid;
            r2_odd   <= r1_odd;
            r2_phase <= n2_phase;
            r2_p2    <= 54'(n2_x) * 54'(n2_y);
            r2_t18   <= r1_t18;
            r2_zero  <= r1_vt[55:27] != 29'd0;
        end
    end

    // stage 3: numerator for all phases but deceleration, remaining distance there
    logic [59:0] n3_n;
    logic [50:0] n3_m;

    always_comb begin
        logic [51:0] twoavt;
        twoavt = {r2_p2[50:0], 1'b0};
        n3_n   = '0;
        n3_m   = '0;
        case (r2_phase)
            PH_TRI_ACC, PH_TRI_DEC: n3_n = 60'(r2_p2);
            PH_TRP_ACC: n3_n = 60'(r2_p2[41:0]) * 60'(r2_t18);
            PH_TRP_CRU: begin
                // behind the cruise start line the position is zero
                if (twoavt >= 52'(s_drv.vvt)) begin
                    n3_n = 60'(twoavt - 52'(s_drv.vvt));
                end
            end
            PH_TRP_DEC: begin
                if (!r2_zero && r2_p2 < 54'(s_drv.k)) begin
                    n3_m = 51'(54'(s_drv.k) - r2_p2);
                end
            end
            default: n3_n = '0;
        endcase
    end

    logic        r3_valid;
    logic        r3_odd;
    t_phase      r3_phase;
    logic [59:0] r3_n;
    logic [50:0] r3_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (s_en) begin
            r3_valid <= r2_valid;
            r3_odd   <= r2_odd;
            r3_phase <= r2_phase;
            r3_n     <= n3_n;
            r3_m     <= n3_m;
        end
    end

    // stage 4: low and cross partial products of the distance square
    logic        r4_valid;
    logic        r4_odd;
    t_phase      r4_phase;
    logic [59:0] r4_n;
    logic [51:0] r4_ll;
    logic [50:0] r4_hl;
    logic [24:0] r4_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (s_en) begin
            r4_valid <= r3_valid;
            r4_odd   <= r3_odd;
            r4_phase <= r3_phase;
            r4_n     <= r3_n;
            r4_ll    <= 52'(r3_m[25:0]) * 52'(r3_m[25:0]);
            r4_hl    <= 51'(r3_m[50:26]) * 51'(r3_m[25:0]);
            r4_h     <= r3_m[50:26];
        end
    end

    // stage 5: high partial, final numerator and divisor
    logic [101:0] n5_n;
    logic [84:0]  n5_d;
    logic         n5_ceil;

    always_comb begin
        logic [49:0]  hh;
        logic [101:0] sq;
        hh = 50'(r4_h) * 50'(r4_h);
        sq = (102'(hh) << 52) + (102'(r4_hl) << 27) + 102'(r4_ll);
        n5_n    = 102'(r4_n);
        n5_ceil = 1'b0;
        case (r4_phase)
            PH_TRI_ACC: n5_d = D_TRI;
            PH_TRI_DEC: begin
                n5_d    = D_TRI;
                n5_ceil = 1'b1;
            end
            PH_TRP_ACC: n5_d = D_ACC;
            PH_TRP_CRU: n5_d = 85'(s_drv.at2);
            PH_TRP_DEC: begin
                n5_d    = s_drv.ddec;
                n5_n    = sq;
                n5_ceil = 1'b1;
            end
            default: n5_d = D_ACC;
        endcase
    end

    logic         r5_valid;
    logic         r5_odd;
    logic         r5_ceil;
    logic [101:0] r5_n;
    logic [84:0]  r5_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (s_en) begin
            r5_valid <= r4_valid;
            r5_odd   <= r4_odd;
            r5_ceil  <= n5_ceil;
            r5_n     <= n5_n;
            r5_d     <= n5_d;
        end
    end

    // quotient chain, 17 bits; anything at or above 2^17 counts as saturated
    assign s_div[0].valid     = r5_valid;
    assign s_div[0].odd       = r5_odd;
    assign s_div[0].ceil_mode = r5_ceil;
    assign s_div[0].sat       = r5_n >= {r5_d, 17'd0};
    assign s_div[0].rem       = r5_n;
    assign s_div[0].dsh       = {r5_d, 16'd0};
    assign s_div[0].q         = '0;

    for (genvar gj = 0; gj < 17; gj++) begin : g_div
        ntmp_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (s_en),
            .i_d     (s_div[gj]),
            .o_q     (s_div[gj + 1])
        );
    end

    // position from quotient: floored directly, or one minus the rounded-up deficit
    logic [17:0] s_pos;

    always_comb begin
        logic [17:0] def;
        def = 18'(s_div[17].q) + 18'(s_div[17].rem != 102'd0);
        if (s_div[17].ceil_mode) begin
            s_pos = (s_div[17].sat || def >= POS_ONE) ? 18'd0 : 18'(POS_ONE - def);
        end else begin
            s_pos = (s_div[17].sat || 18'(s_div[17].q) > POS_ONE)
                  ? POS_ONE : 18'(s_div[17].q);
        end
    end

    // output register with one spare slot
    logic        r_head_odd;
    logic [17:0] r_head_pos;
    logic        r_spare_odd;
    logic [17:0] r_spare_pos;
    logic [1:0]  n_cnt;
    logic        s_push;
    logic        s_pop;

    assign s_push = s_en && s_div[17].valid;
    assign s_pop  = (r_cnt != 2'd0) && !i_out_stall;

    always_comb begin
        n_cnt = r_cnt;
        case (r_cnt)
            2'd0: if (s_push) n_cnt = 2'd1;
            2'd1: begin
                if (s_push && !s_pop) n_cnt = 2'd2;
                else if (!s_push && s_pop) n_cnt = 2'd0;
            end
            2'd2: if (s_pop) n_cnt = 2'd1;
            default: n_cnt = 2'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_cnt)
            2'd0: begin
                if (s_push) begin
                    r_head_pos <= s_pos;
                    r_head_odd <= s_div[17].odd;
                end
            end
            2'd1: begin
                if (s_push && s_pop) begin
                    r_head_pos <= s_pos;
                    r_head_odd <= s_div[17].odd;
                end else if (s_push) begin
                    r_spare_pos <= s_pos;
                    r_spare_odd <= s_div[17].odd;
                end
            end
            2'd2: begin
                if (s_pop) begin
                    r_head_pos <= r_spare_pos;
                    r_head_odd <= r_spare_odd;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid  = r_cnt != 2'd0;
    assign o_position   = r_head_pos;
    assign o_odd_period = r_head_odd;

endmodule
